// ===== rtl/worst_fit_cell_allocator_assert.svh =====
// assertion macros for the worst-fit cell allocator
`ifndef WORST_FIT_CELL_ALLOCATOR_ASSERT_SVH
`define WORST_FIT_CELL_ALLOCATOR_ASSERT_SVH

`ifndef SYNTHESIS
`define WFCA_ASSERT_SAME(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);
`define WFCA_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);
`else
`define WFCA_ASSERT_SAME(lbl, ante, cons, msg)
`define WFCA_ASSERT_NEXT(lbl, ante, cons, msg)
`endif

`endif

// ===== rtl/wfca_pkg.sv =====
// shared types and constants for the worst-fit cell allocator
package wfca_pkg;

    localparam int CELL_COUNT = 1024;
    localparam int OWNER_BITS = 8;
    localparam int ADDR_BITS  = $clog2(CELL_COUNT);
    localparam int LEN_BITS   = $clog2(CELL_COUNT + 1);

    typedef logic [ADDR_BITS-1:0]  addr_t;
    typedef logic [LEN_BITS-1:0]   len_t;
    typedef logic [OWNER_BITS-1:0] owner_t;
    typedef logic [ADDR_BITS:0]    cnt_t;
    typedef logic [1:0]            status_t;

    localparam cnt_t CNT_END  = cnt_t'(CELL_COUNT);
    localparam cnt_t CNT_LAST = cnt_t'(CELL_COUNT - 1);

    localparam logic ACT_ALLOC   = 1'b0;
    localparam logic ACT_RELEASE = 1'b1;

    localparam status_t STATUS_OK       = 2'd0;
    localparam status_t STATUS_FAIL     = 2'd1;
    localparam status_t STATUS_RELEASED = 2'd2;

    typedef struct packed {
        logic   used;
        owner_t owner;
    } cell_t;

    typedef struct packed {
        logic  clear;
        logic  valid;
        logic  free;
        addr_t addr;
    } scan_t;

endpackage

// ===== rtl/wfca_cell_ram.sv =====
// cell map memory: used flag and owner per cell, one write and one registered read port
module wfca_cell_ram (
    input  logic           clk,
    input  logic           we,
    input  wfca_pkg::addr_t waddr,
    input  wfca_pkg::cell_t wdata,
    input  logic           re,
    input  wfca_pkg::addr_t raddr,
    output wfca_pkg::cell_t rdata
);
    import wfca_pkg::*;

    cell_t mem [CELL_COUNT];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    always_ff @(posedge clk)
    begin
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

// ===== rtl/wfca_run_tracker.sv =====
// free-run length tracker: one increment and one compare per scanned cell
module wfca_run_tracker (
    input  logic            clk,
    input  logic            rst_n,
    input  wfca_pkg::scan_t scan,
    output wfca_pkg::len_t  best_len,
    output wfca_pkg::addr_t best_start
);
    import wfca_pkg::*;

    len_t  run_len_reg, run_len_next;
    addr_t run_start_reg, run_start_next;
    len_t  best_len_reg, best_len_next;
    addr_t best_start_reg, best_start_next;

    always_comb
    begin
        run_len_next    = run_len_reg;
        run_start_next  = run_start_reg;
        best_len_next   = best_len_reg;
        best_start_next = best_start_reg;
        if (scan.clear)
        begin
            run_len_next    = '0;
            run_start_next  = '0;
            best_len_next   = '0;
            best_start_next = '0;
        end
        else if (scan.valid)
        begin
            if (scan.free)
            begin
                run_len_next = run_len_reg + len_t'(1);
                if (run_len_reg == '0)
                begin
                    run_start_next = scan.addr;
                end
                // strict compare keeps the lowest run on a tie
                if (run_len_next > best_len_reg)
                begin
                    best_len_next   = run_len_next;
                    best_start_next = run_start_next;
                end
            end
            else
            begin
                run_len_next = '0;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            run_len_reg    <= '0;
            run_start_reg  <= '0;
            best_len_reg   <= '0;
            best_start_reg <= '0;
        end
        else
        begin
            run_len_reg    <= run_len_next;
            run_start_reg  <= run_start_next;
            best_len_reg   <= best_len_next;
            best_start_reg <= best_start_next;
        end
    end

    assign best_len   = best_len_reg;
    assign best_start = best_start_reg;

endmodule

// ===== rtl/worst_fit_cell_allocator.sv =====
// worst-fit cell allocator top level: sequencer, map memory and run tracker
// after reset a clearing pass over all 1024 cells runs with busy high
// release: done strobes after one map pass from the accepted transaction
// allocate: done after one map pass, plus a fill of request_size cells when granted
// busy from acceptance until the done cycle; next transaction at the edge ending it
// results are on the ports under done and hold until the next result; the receiver cannot stall
module worst_fit_cell_allocator (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               start,
    output logic               busy,
    input  logic               action,
    input  wfca_pkg::owner_t   owner,
    input  wfca_pkg::len_t     request_size,
    output logic               done,
    output wfca_pkg::status_t  status,
    output wfca_pkg::addr_t    block_start,
    output wfca_pkg::len_t     largest_free
);
    import wfca_pkg::*;

`include "worst_fit_cell_allocator_assert.svh"

    typedef enum logic [3:0] {
        S_CLEAR = 4'b0001,
        S_IDLE  = 4'b0010,
        S_SCAN  = 4'b0100,
        S_FILL  = 4'b1000
    } state_t;

    state_t  state_reg, state_next;
    cnt_t    cnt_reg, cnt_next;
    logic    rd_valid_reg, rd_valid_next;
    addr_t   rd_addr_q_reg, rd_addr_q_next;
    logic    action_reg, action_next;
    owner_t  owner_reg, owner_next;
    len_t    size_reg, size_next;
    addr_t   fill_addr_reg, fill_addr_next;
    len_t    fill_left_reg, fill_left_next;
    logic    done_reg, done_next;
    status_t status_reg, status_next;
    addr_t   start_reg, start_next;
    len_t    largest_reg, largest_next;

    logic    accept;
    logic    ram_we;
    addr_t   ram_waddr;
    cell_t   ram_wdata;
    logic    ram_re;
    addr_t   ram_raddr;
    cell_t   ram_rdata;
    scan_t   scan;
    len_t    best_len;
    addr_t   best_start;

    assign accept = start && (state_reg == S_IDLE);

    wfca_cell_ram u_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .re    (ram_re),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    assign scan.clear = accept;
    assign scan.valid = rd_valid_reg;
    assign scan.free  = !ram_rdata.used;
    assign scan.addr  = rd_addr_q_reg;

    wfca_run_tracker u_tracker (
        .clk        (clk),
        .rst_n      (rst_n),
        .scan       (scan),
        .best_len   (best_len),
        .best_start (best_start)
    );

    // memory ports
    always_comb
    begin
        ram_we    = 1'b0;
        ram_waddr = cnt_reg[ADDR_BITS-1:0];
        ram_wdata = '{used: 1'b0, owner: '0};
        ram_re    = (state_reg == S_SCAN) && (cnt_reg != CNT_END);
        ram_raddr = cnt_reg[ADDR_BITS-1:0];
        unique case (state_reg)
            S_CLEAR:
            begin
                ram_we = 1'b1;
            end
            S_SCAN:
            begin
                if (action_reg == ACT_RELEASE && rd_valid_reg && ram_rdata.used
                    && ram_rdata.owner == owner_reg)
                begin
                    ram_we    = 1'b1;
                    ram_waddr = rd_addr_q_reg;
                    ram_wdata = '{used: 1'b0, owner: ram_rdata.owner};
                end
            end
            S_FILL:
            begin
                ram_we    = 1'b1;
                ram_waddr = fill_addr_reg;
                ram_wdata = '{used: 1'b1, owner: owner_reg};
            end
            S_IDLE:
            begin
            end
            default:
            begin
            end
        endcase
    end

    // sequencer
    always_comb
    begin
        state_next     = state_reg;
        cnt_next       = cnt_reg;
        rd_valid_next  = ram_re;
        rd_addr_q_next = ram_raddr;
        action_next    = action_reg;
        owner_next     = owner_reg;
        size_next      = size_reg;
        fill_addr_next = fill_addr_reg;
        fill_left_next = fill_left_reg;
        done_next      = 1'b0;
        status_next    = status_reg;
        start_next     = start_reg;
        largest_next   = largest_reg;
        unique case (state_reg)
            S_CLEAR:
            begin
                if (cnt_reg == CNT_LAST)
                begin
                    cnt_next   = '0;
                    state_next = S_IDLE;
                end
                else
                begin
                    cnt_next = cnt_reg + cnt_t'(1);
                end
            end
            S_IDLE:
            begin
                if (accept)
                begin
                    action_next = action;
                    owner_next  = owner;
                    size_next   = request_size;
                    cnt_next    = '0;
                    state_next  = S_SCAN;
                end
            end
            S_SCAN:
            begin
                if (cnt_reg != CNT_END)
                begin
                    cnt_next = cnt_reg + cnt_t'(1);
                end
                else if (!rd_valid_reg)
                begin
                    // whole map seen, tracker holds the widest run
                    if (action_reg == ACT_RELEASE)
                    begin
                        status_next  = STATUS_RELEASED;
                        start_next   = '0;
                        largest_next = '0;
                        done_next    = 1'b1;
                        state_next   = S_IDLE;
                    end
                    else if (best_len >= size_reg)
                    begin
                        status_next  = STATUS_OK;
                        start_next   = best_start;
                        largest_next = best_len;
                        if (size_reg == '0)
                        begin
                            done_next  = 1'b1;
                            state_next = S_IDLE;
                        end
                        else
                        begin
                            fill_addr_next = best_start;
                            fill_left_next = size_reg;
                            state_next     = S_FILL;
                        end
                    end
                    else
                    begin
                        status_next  = STATUS_FAIL;
                        start_next   = '0;
                        largest_next = best_len;
                        done_next    = 1'b1;
                        state_next   = S_IDLE;
                    end
                end
            end
            S_FILL:
            begin
                fill_addr_next = fill_addr_reg + addr_t'(1);
                fill_left_next = fill_left_reg - len_t'(1);
                if (fill_left_reg == len_t'(1))
                begin
                    done_next  = 1'b1;
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= S_CLEAR;
            cnt_reg      <= '0;
            rd_valid_reg <= 1'b0;
            done_reg     <= 1'b0;
        end
        else
        begin
            state_reg    <= state_next;
            cnt_reg      <= cnt_next;
            rd_valid_reg <= rd_valid_next;
            done_reg     <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rd_addr_q_reg <= rd_addr_q_next;
        action_reg    <= action_next;
        owner_reg     <= owner_next;
        size_reg      <= size_next;
        fill_addr_reg <= fill_addr_next;
        fill_left_reg <= fill_left_next;
        status_reg    <= status_next;
        start_reg     <= start_next;
        largest_reg   <= largest_next;
    end

    assign busy         = (state_reg != S_IDLE);
    assign done         = done_reg;
    assign status       = status_reg;
    assign block_start  = start_reg;
    assign largest_free = largest_reg;

    `WFCA_ASSERT_SAME(a_done_idle, done, !busy, "done while sequencer busy")
    `WFCA_ASSERT_NEXT(a_accept_busy, start && !busy, busy, "accepted transaction did not start")
    `WFCA_ASSERT_SAME(a_fail_start, done && status == STATUS_FAIL, block_start == '0,
                      "failed allocate reports nonzero start")
    `WFCA_ASSERT_SAME(a_fill_fits, state_reg == S_FILL,
                      fill_left_reg != '0 && fill_left_reg <= largest_reg,
                      "fill runs past the granted run")
    `WFCA_ASSERT_SAME(a_read_scan, ram_re, state_reg == S_SCAN && !ram_we || ram_re && ram_we
                      && ram_waddr != ram_raddr, "map read collides with write")

endmodule

// ===== sim/tb.sv =====
// testbench for the worst-fit cell allocator: cell map scoreboard, request drivers and checks
module tb;
    timeunit 1ns;
    timeprecision 1ps;

    import wfca_pkg::*;

    typedef struct packed {
        status_t status;
        addr_t   first;
        len_t    largest;
    } alloc_result_t;

    class cell_map_model;
        bit            cell_used [CELL_COUNT];
        owner_t        cell_owner [CELL_COUNT];
        alloc_result_t pending_responses [$];
        int unsigned   errors;
        int unsigned   n_granted;
        int unsigned   n_refused;
        int unsigned   n_released;

        function len_t longest_run(output addr_t run_start);
            int best_len;
            int best_at;
            int cur_len;
            int cur_at;
            best_len = 0;
            best_at  = 0;
            cur_len  = 0;
            cur_at   = 0;
            for (int i = 0; i < CELL_COUNT; i++)
            begin
                if (!cell_used[i])
                begin
                    if (cur_len == 0)
                        cur_at = i;
                    cur_len++;
                    if (cur_len > best_len)
                    begin
                        best_len = cur_len;
                        best_at  = cur_at;
                    end
                end
                else
                    cur_len = 0;
            end
            run_start = addr_t'(best_at);
            return len_t'(best_len);
        endfunction

        function void apply_request(logic act, owner_t own, len_t size);
            alloc_result_t r;
            addr_t         at;
            len_t          run_len;
            if (act == ACT_RELEASE)
            begin
                foreach (cell_used[i])
                    if (cell_used[i] && cell_owner[i] == own)
                        cell_used[i] = 1'b0;
                r.status  = STATUS_RELEASED;
                r.first   = '0;
                r.largest = '0;
                n_released++;
            end
            else
            begin
                run_len   = longest_run(at);
                r.largest = run_len;
                if (run_len >= size)
                begin
                    for (int i = 0; i < int'(size); i++)
                    begin
                        cell_used[int'(at) + i]  = 1'b1;
                        cell_owner[int'(at) + i] = own;
                    end
                    r.status = STATUS_OK;
                    r.first  = at;
                    n_granted++;
                end
                else
                begin
                    r.status = STATUS_FAIL;
                    r.first  = '0;
                    n_refused++;
                end
            end
            pending_responses.push_back(r);
        endfunction

        function void check_response(status_t st, addr_t bs, len_t lf);
            alloc_result_t exp;
            if (pending_responses.size() == 0)
            begin
                $error("result with no transaction outstanding: status %0d start %0d largest %0d",
                       st, bs, lf);
                errors++;
                return;
            end
            exp = pending_responses.pop_front();
            if (st !== exp.status)
            begin
                $error("status: expected %0d, got %0d", exp.status, st);
                errors++;
            end
            if (bs !== exp.first)
            begin
                $error("block_start: expected %0d, got %0d", exp.first, bs);
                errors++;
            end
            if (lf !== exp.largest)
            begin
                $error("largest_free: expected %0d, got %0d", exp.largest, lf);
                errors++;
            end
        endfunction

        function int pending();
            return pending_responses.size();
        endfunction
    endclass

    logic    clk          = 1'b0;
    logic    rst_n        = 1'b0;
    logic    start        = 1'b0;
    logic    action       = ACT_ALLOC;
    owner_t  owner        = '0;
    len_t    request_size = '0;
    logic    busy;
    logic    done;
    status_t status;
    addr_t   block_start;
    len_t    largest_free;

    cell_map_model model = new();
    owner_t        owner_pool [8];
    int            idle_pct [4] = '{0, 86, 0, 7};

    worst_fit_cell_allocator u_dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .start        (start),
        .busy         (busy),
        .action       (action),
        .owner        (owner),
        .request_size (request_size),
        .done         (done),
        .status       (status),
        .block_start  (block_start),
        .largest_free (largest_free)
    );

    always #5 clk = ~clk;

    always @(posedge clk)
    begin
        if (rst_n && done)
            model.check_response(status, block_start, largest_free);
    end

    task automatic send_request(input logic act, input owner_t own, input len_t size);
        start        <= 1'b1;
        action       <= act;
        owner        <= own;
        request_size <= size;
        do @(posedge clk); while (busy);
        model.apply_request(act, own, size);
    endtask

    task automatic idle_gap(input int pct);
        if ($urandom_range(99) < pct)
        begin
            start <= 1'b0;
            do @(posedge clk); while ($urandom_range(99) < pct);
        end
    endtask

    task automatic wait_quiet();
        start <= 1'b0;
        @(posedge clk);
        while (model.pending() != 0)
            @(posedge clk);
    endtask

    task automatic random_request();
        int     pick;
        addr_t  run_at;
        len_t   big;
        owner_t own;
        len_t   size;
        if ($urandom_range(9) == 0)
            own = owner_t'($urandom_range(255));
        else
            own = owner_pool[$urandom_range(7)];
        pick = $urandom_range(99);
        if (pick < 22)
            send_request(ACT_RELEASE, own, len_t'($urandom_range(1024)));
        else
        begin
            big = model.longest_run(run_at);
            if (pick < 32)
                size = big;
            else if (pick < 38)
                size = (big == len_t'(CELL_COUNT)) ? big : big + 1'b1;
            else if (pick < 40)
                size = len_t'(CELL_COUNT);
            else if (pick < 45)
                size = '0;
            else if (pick < 85)
                size = len_t'($urandom_range(48, 1));
            else
                size = len_t'($urandom_range(400, 49));
            send_request(ACT_ALLOC, own, size);
        end
    endtask

    initial
    begin
        foreach (owner_pool[i])
            owner_pool[i] = owner_t'($urandom_range(255));
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // empty map, full map, failures, ties and exact fits
        send_request(ACT_ALLOC,   8'h00, 11'd0);
        send_request(ACT_ALLOC,   8'hFF, 11'd1024);
        send_request(ACT_ALLOC,   8'h00, 11'd0);
        send_request(ACT_ALLOC,   8'hAA, 11'd1);
        send_request(ACT_RELEASE, 8'h55, 11'd0);
        send_request(ACT_RELEASE, 8'hFF, 11'd1024);
        send_request(ACT_ALLOC,   8'hAA, 11'd300);
        send_request(ACT_ALLOC,   8'h55, 11'd100);
        send_request(ACT_ALLOC,   8'h0F, 11'd300);
        send_request(ACT_ALLOC,   8'hF0, 11'd324);
        send_request(ACT_RELEASE, 8'hAA, 11'd0);
        send_request(ACT_RELEASE, 8'h0F, 11'd0);
        send_request(ACT_ALLOC,   8'h01, 11'd50);
        send_request(ACT_ALLOC,   8'h02, 11'd301);
        send_request(ACT_ALLOC,   8'h02, 11'd300);
        send_request(ACT_ALLOC,   8'h03, 11'd250);
        send_request(ACT_RELEASE, 8'h01, 11'd0);
        send_request(ACT_RELEASE, 8'h02, 11'd0);
        send_request(ACT_RELEASE, 8'h03, 11'd0);
        send_request(ACT_RELEASE, 8'h55, 11'd0);
        send_request(ACT_RELEASE, 8'hF0, 11'd0);
        send_request(ACT_ALLOC,   8'h80, 11'd1024);
        send_request(ACT_RELEASE, 8'h80, 11'd1);

        for (int p = 0; p < 4; p++)
        begin
            wait_quiet();
            for (int i = 0; i < 65; i++)
            begin
                random_request();
                idle_gap(idle_pct[p]);
            end
        end

        wait_quiet();
        repeat (2100) @(posedge clk);
        $display("covered %0d transactions: %0d granted, %0d refused, %0d releases",
                 model.n_granted + model.n_refused + model.n_released,
                 model.n_granted, model.n_refused, model.n_released);
        if (model.errors == 0)
            $display("simulation ok");
        else
            $display("simulation failed");
        $finish;
    end

    initial
    begin
        #30ms;
        $display("simulation failed");
        $finish;
    end

endmodule

// ===== files.f =====
+incdir+rtl
rtl/wfca_pkg.sv
rtl/wfca_cell_ram.sv
rtl/wfca_run_tracker.sv
rtl/worst_fit_cell_allocator.sv
sim/tb.sv
